// ----- rtl/rbd_pkg.sv -----
`timescale 1ns / 1ps
package rbd_pkg;

	// one cipher block is two 64-bit halves
	localparam int unsigned HALF_W  = 64;
	localparam int unsigned BLOCK_W = 2 * HALF_W;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_DECIDE = 3'b100
	} rbd_state_t;

endpackage

// ----- rtl/rbd_store.sv -----
`timescale 1ns / 1ps
module rbd_store #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned IDX_W = 6
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [IDX_W-1:0]            wr_addr,
	input  logic [rbd_pkg::BLOCK_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [IDX_W-1:0]            rd_addr,
	output logic [rbd_pkg::BLOCK_W-1:0] rd_data
);

	logic [rbd_pkg::BLOCK_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/repeated_block_detector.sv -----
`timescale 1ns / 1ps
// Repeated block detector.
// Input channel: in_valid / in_stall with block_high, block_low, last_block.
// A transfer is taken when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with block_is_repeat,
// message_has_repeat, store_overflow and message_end, one result per block.
// Each block is compared against the distinct blocks stored so far in this
// message, one stored entry per cycle through a single 128-bit comparator fed
// by the store's registered read port, and the scan stops at the first hit.
// in_stall stays high until the result is loaded into the output register, so a
// new block is taken only after the previous result has been loaded.
// A distinct block is appended to the store unless the store holds MAX_BLOCKS
// entries, in which case the sticky overflow flag is set instead.
// After the block marked last_block the store count and both flags clear.
// Reset clears the count, the flags and the output valid bit; stored entries
// are not cleared, they are never read before being written.
// While out_stall holds a result, the next block is still taken and scanned;
// it waits for the output register before it updates the store.
module repeated_block_detector #(
	parameter int unsigned MAX_BLOCKS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	input  logic        last_block,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        block_is_repeat,
	output logic        message_has_repeat,
	output logic        store_overflow,
	output logic        message_end
);

	localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);

	rbd_pkg::rbd_state_t state_q;

	logic [rbd_pkg::BLOCK_W-1:0] block_q;
	logic                        last_q;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            issue_q;
	logic                        rd_vld_s1;
	logic                        found_q;
	logic                        rep_q;
	logic                        ovf_q;

	logic                        out_valid_q;
	logic                        is_rep_q;
	logic                        has_rep_q;
	logic                        ovf_out_q;
	logic                        end_q;

	logic                        in_xfer;
	logic                        out_xfer;
	logic                        issuing;
	logic                        hit;
	logic                        dec_go;
	logic                        store_ok;
	logic                        new_rep;
	logic                        new_ovf;
	logic [rbd_pkg::BLOCK_W-1:0] rd_data;

	assign in_stall  = (state_q != rbd_pkg::ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_xfer  = out_valid_q && !out_stall;

	assign hit       = rd_vld_s1 && (rd_data == block_q);
	assign issuing   = (state_q == rbd_pkg::ST_SCAN) && (issue_q < count_q) && !hit;

	// output register must be free or draining this cycle
	assign dec_go    = (state_q == rbd_pkg::ST_DECIDE) && (!out_valid_q || !out_stall);
	assign store_ok  = !found_q && (count_q < MAX_CNT);
	assign new_rep   = rep_q | found_q;
	assign new_ovf   = ovf_q | (!found_q && !store_ok);

	rbd_store #(
		.DEPTH (MAX_BLOCKS),
		.IDX_W (IDX_W)
	) u_store (
		.clk     (clk),
		.wr_en   (dec_go && store_ok),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (block_q),
		.rd_en   (issuing),
		.rd_addr (issue_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			block_q <= {block_high, block_low};
			last_q  <= last_block;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rbd_pkg::ST_IDLE;
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			count_q   <= '0;
			rep_q     <= 1'b0;
			ovf_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= issuing;
			case (state_q)
				rbd_pkg::ST_IDLE: begin
					if (in_xfer) begin
						issue_q <= '0;
						state_q <= rbd_pkg::ST_SCAN;
					end
				end
				rbd_pkg::ST_SCAN: begin
					if (issuing) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (hit) begin
						found_q <= 1'b1;
						state_q <= rbd_pkg::ST_DECIDE;
					end else if (!issuing && !rd_vld_s1) begin
						found_q <= 1'b0;
						state_q <= rbd_pkg::ST_DECIDE;
					end
				end
				rbd_pkg::ST_DECIDE: begin
					if (dec_go) begin
						if (last_q) begin
							count_q <= '0;
							rep_q   <= 1'b0;
							ovf_q   <= 1'b0;
						end else begin
							count_q <= count_q + CNT_W'(store_ok);
							rep_q   <= new_rep;
							ovf_q   <= new_ovf;
						end
						state_q <= rbd_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= rbd_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dec_go) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_go) begin
			is_rep_q  <= found_q;
			has_rep_q <= new_rep;
			ovf_out_q <= new_ovf;
			end_q     <= last_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign block_is_repeat    = is_rep_q;
	assign message_has_repeat = has_rep_q;
	assign store_overflow     = ovf_out_q;
	assign message_end        = end_q;

	// checks

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("store count beyond capacity");

	a_hit_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rbd_pkg::ST_DECIDE && found_q) |-> (count_q != '0))
		else $error("repeat found in an empty store");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(dec_go && last_q) |=> (count_q == '0 && !rep_q && !ovf_q))
		else $error("message state not cleared after last block");

	a_repeat_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_rep_q) |-> has_rep_q)
		else $error("repeat block without message repeat flag");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rbd_pkg::ST_SCAN) |-> (issue_q <= count_q))
		else $error("scan index ran past stored entries");

endmodule

// ----- verif/tb_repeated_block_detector.sv -----
`timescale 1ns / 1ps
module tb_repeated_block_detector;

	localparam int STORE_DEPTH    = 64;
	localparam int ITEM_TARGET    = 2000;
	localparam int PAUSE_AT       = 1000;
	localparam int LONG_HOLD_AT   = 600;
	localparam int LONG_HOLD_LEN  = 300;
	localparam int WATCHDOG_LIMIT = 10000;
	localparam int SETTLE_CYCLES  = STORE_DEPTH + 40;
	localparam int N_DIR          = 17;

	// field order: is_repeat, has_repeat, overflow, msg_end
	typedef struct packed {
		logic is_repeat;
		logic has_repeat;
		logic overflow;
		logic msg_end;
	} verdict_t;

	typedef struct {
		logic [rbd_pkg::HALF_W-1:0] hi;
		logic [rbd_pkg::HALF_W-1:0] lo;
		logic                       last;
		bit                         pinned;
		verdict_t                   want;
	} dir_row_t;

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [rbd_pkg::HALF_W-1:0] block_high = '0;
	logic [rbd_pkg::HALF_W-1:0] block_low = '0;
	logic                       last_block = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       block_is_repeat;
	logic                       message_has_repeat;
	logic                       store_overflow;
	logic                       message_end;

	// typed expectation attached to the block currently offered
	bit       pin_valid = 1'b0;
	verdict_t pin_want = '0;

	// predictor state
	logic [rbd_pkg::BLOCK_W-1:0] seen_store [STORE_DEPTH];
	int                          stored_n = 0;
	logic                        rep_flag = 1'b0;
	logic                        ovf_flag = 1'b0;

	verdict_t verdict_q [$];

	int  errors = 0;
	int  blocks_offered = 0;
	int  blocks_in = 0;
	int  results_out = 0;
	int  repeats_seen = 0;
	int  messages_seen = 0;
	int  overflow_msgs = 0;
	int  idle_cycles = 0;
	int  burst_left = 0;
	bit  run_done = 1'b0;
	bit  hold_done = 1'b0;

	dir_row_t dir_rows [N_DIR] = '{
		'{64'h0, 64'h0, 1'b0, 1'b1, 4'b0000},                  // first block after reset
		'{64'h0, 64'h0, 1'b0, 1'b1, 4'b1100},
		'{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 4'b0100},
		'{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 4'b1101},
		// one-block message, flags start clear again
		'{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 4'b0001},
		'{64'h0, 64'h1, 1'b0, 1'b1, 4'b0000},
		'{64'h1, 64'h0, 1'b0, 1'b1, 4'b0000},                  // halves swapped
		'{64'h0, 64'h1, 1'b0, 1'b1, 4'b1100},
		'{64'h8000_0000_0000_0000, 64'h0, 1'b0, 1'b0, 4'b0000},
		'{64'h0, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 4'b0000},
		'{64'h8000_0000_0000_0000, 64'h0, 1'b0, 1'b0, 4'b0000},
		'{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 4'b0000},
		'{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 4'b0000},
		'{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1, 1'b0, 4'b0000},
		'{64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 4'b0000},
		'{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0, 4'b0000},
		'{64'h0, 64'h0, 1'b1, 1'b1, 4'b0001}                   // store was cleared at end
	};

	repeated_block_detector #(
		.MAX_BLOCKS(STORE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.block_high(block_high),
		.block_low(block_low),
		.last_block(last_block),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.block_is_repeat(block_is_repeat),
		.message_has_repeat(message_has_repeat),
		.store_overflow(store_overflow),
		.message_end(message_end)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// repeat detection over the distinct blocks of the current message
	function automatic verdict_t judge_block(logic [rbd_pkg::BLOCK_W-1:0] blk, logic last);
		verdict_t v;
		logic     hit;
		hit = 1'b0;
		for (int i = 0; i < stored_n; i++)
			if (seen_store[i] == blk)
				hit = 1'b1;
		if (hit)
			rep_flag = 1'b1;
		else if (stored_n < STORE_DEPTH) begin
			seen_store[stored_n] = blk;
			stored_n++;
		end else
			ovf_flag = 1'b1;
		v = '{hit, rep_flag, ovf_flag, last};
		if (last) begin
			stored_n = 0;
			rep_flag = 1'b0;
			ovf_flag = 1'b0;
		end
		return v;
	endfunction

	function automatic logic [rbd_pkg::BLOCK_W-1:0] random_block();
		logic [rbd_pkg::BLOCK_W-1:0] b;
		case ($urandom_range(0, 15))
			0: b = '0;
			1: b = '1;
			2: b = {{(rbd_pkg::BLOCK_W-1){1'b0}}, 1'b1}
				<< $urandom_range(0, rbd_pkg::BLOCK_W - 1);
			default: b = {$urandom, $urandom, $urandom, $urandom};
		endcase
		return b;
	endfunction

	always @(posedge clk) begin : monitor
		verdict_t want;
		verdict_t got;
		string    names [4];
		names = '{"block_is_repeat", "message_has_repeat", "store_overflow", "message_end"};
		if (in_valid && !in_stall) begin
			want = judge_block({block_high, block_low}, last_block);
			if (pin_valid)
				want = pin_want;
			verdict_q.push_back(want);
			blocks_in++;
		end
		if (out_valid && !out_stall) begin
			got = '{block_is_repeat, message_has_repeat, store_overflow, message_end};
			results_out++;
			if (verdict_q.size() == 0) begin
				$error("result transfer with no block pending");
				errors++;
			end else begin
				want = verdict_q.pop_front();
				for (int i = 0; i < 4; i++)
					if (got[3 - i] !== want[3 - i]) begin
						$error("%s: expected %0b, got %0b", names[i], want[3 - i],
							got[3 - i]);
						errors++;
					end
				if (got.is_repeat === 1'b1)
					repeats_seen++;
				if (got.msg_end === 1'b1) begin
					messages_seen++;
					if (got.overflow === 1'b1)
						overflow_msgs++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && !run_done) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// receiver: changing stall modes, plus one long hold-off
	initial begin : receiver
		int mode;
		int mode_left;
		int hold_left;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (!hold_done && results_out >= LONG_HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	task automatic offer_block(logic [rbd_pkg::BLOCK_W-1:0] blk, logic last, bit pinned,
			verdict_t want);
		int gap;
		if (burst_left == 0) begin
			// every third stretch of items is sent back to back
			if ((blocks_offered / 300) % 3 == 0)
				gap = 0;
			else if ($urandom_range(0, 9) == 0)
				gap = $urandom_range(10, 40);
			else
				gap = $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		{block_high, block_low} <= blk;
		last_block <= last;
		pin_valid <= pinned;
		pin_want <= want;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		blocks_offered++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
	endtask

	// long messages can hold more distinct blocks than the store and may repeat dropped ones
	task automatic run_message(bit long_kind);
		logic [rbd_pkg::BLOCK_W-1:0] pool [$];
		logic [rbd_pkg::BLOCK_W-1:0] blk;
		int                          pool_n;
		int                          len;
		if (long_kind) begin
			pool_n = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 16);
			len = pool_n + $urandom_range(0, 30);
		end else begin
			pool_n = $urandom_range(1, 12);
			len = $urandom_range(1, 24);
		end
		for (int i = 0; i < pool_n; i++)
			if (i > 0 && $urandom_range(0, 3) == 0)
				pool.push_back(pool[$urandom_range(0, i - 1)]
					^ ({{(rbd_pkg::BLOCK_W-1){1'b0}}, 1'b1}
					<< $urandom_range(0, rbd_pkg::BLOCK_W - 1)));
			else
				pool.push_back(random_block());
		for (int j = 0; j < len; j++) begin
			if (long_kind && j < pool_n)
				blk = pool[j];
			else if ($urandom_range(0, 9) < 7)
				blk = pool[$urandom_range(0, pool_n - 1)];
			else
				blk = random_block();
			offer_block(blk, j == len - 1, 1'b0, '0);
		end
	endtask

	initial begin : stimulus
		bit paused;
		int msg_idx;
		paused = 1'b0;
		msg_idx = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < N_DIR; r++)
			offer_block({dir_rows[r].hi, dir_rows[r].lo}, dir_rows[r].last,
				dir_rows[r].pinned, dir_rows[r].want);

		while (blocks_offered < ITEM_TARGET) begin
			if (!paused && blocks_offered >= PAUSE_AT) begin
				drain_results();
				paused = 1'b1;
			end
			run_message(msg_idx % 6 == 1 || $urandom_range(0, 9) == 0);
			msg_idx++;
		end

		drain_results();
		run_done = 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d blocks in %0d messages, %0d flagged as repeats", blocks_in,
			messages_seen, repeats_seen);
		$display("%0d messages overflowed the %0d-entry store", overflow_msgs, STORE_DEPTH);
		if (errors == 0 && verdict_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
